FILE: sv/nds_pkg.sv
// ---------------------------------------------------------------------------
// nds_pkg: shared types and constants for the nutrient diffusion sweep
// Grid geometry, payload structs, register indexes and controller commands.
// ---------------------------------------------------------------------------
package nds_pkg;

  localparam int GridSize = 64;
  localparam int Cells    = GridSize * GridSize;
  localparam int AddrW    = $clog2(Cells);
  localparam int CoordW   = $clog2(GridSize);
  localparam int ValW     = 17;
  localparam logic [ValW-1:0] OneQ16 = 17'h10000;

  typedef enum logic [2:0] {
    REG_GAIN  = 3'd0,
    REG_STEP  = 3'd1,
    REG_ALPHA = 3'd2,
    REG_WC1   = 3'd3,
    REG_WC2   = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_INIT  = 2'd1,
    MODE_SWEEP = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] cancer_count;
    logic [7:0] normal_count;
  } nds_in_t;

  typedef struct packed {
    logic [16:0] nutrient_first;
    logic [16:0] nutrient_second;
    logic        op_done;
  } nds_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_counts;   // write counts at addr
    logic             clr_counts;  // clear pass write of zero counts
    logic             wr_init;     // write init value at addr
    logic             rd;          // issue read at addr (the cell of the tap in rd_sel)
    logic [2:0]       rd_sel;      // which stencil tap: 0 c,1 n,2 s,3 w,4 e
    logic             wr_res;      // write computed result at addr
    logic [AddrW-1:0] addr;
  } nds_cmd_t;

  localparam logic [2:0] TapC = 3'd0;
  localparam logic [2:0] TapN = 3'd1;
  localparam logic [2:0] TapS = 3'd2;
  localparam logic [2:0] TapW = 3'd3;
  localparam logic [2:0] TapE = 3'd4;

  // Saturating fixed-point update of one value
  function automatic logic [ValW-1:0] sat_result(input logic signed [51:0] t);
    logic signed [52:0] r;
    begin
      r = {t[51], t} + 53'sd32768;
      if (t < 0) sat_result = '0;
      else if ((r >>> 16) > 53'sd65536) sat_result = OneQ16;
      else sat_result = r[32:16];
    end
  endfunction

endpackage

FILE: sv/nds_datapath.sv
// ---------------------------------------------------------------------------
// nds_datapath: field memories, count stores and the cell update arithmetic
// Reads the five stencil taps one per cycle, then runs a short multiply pipe.
// ---------------------------------------------------------------------------
module nds_datapath
  import nds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  nds_cmd_t    cmd_i,
  input  logic [7:0]  cancer_i,
  input  logic [7:0]  normal_i,
  input  logic [15:0] gain_i,
  input  logic [15:0] step_i,
  input  logic [15:0] alpha_i,
  input  logic [15:0] wc1_i,
  input  logic [15:0] wc2_i,
  input  logic        calc_i,     // taps complete, start arithmetic
  output logic        calc_done_o,
  output logic [16:0] rd_first_o,
  output logic [16:0] rd_second_o
);

  logic [ValW-1:0] mem1 [Cells];
  logic [ValW-1:0] mem2 [Cells];
  logic [7:0]      memc [Cells];
  logic [7:0]      memn [Cells];

  logic [ValW-1:0] rd1_q, rd2_q;
  logic [7:0]      rdc_q, rdn_q;
  logic [2:0]      tap_q;
  logic            rdv_q;
  logic [ValW-1:0] res1_q, res2_q;

  // Field memories: one write, one read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_init) begin
      mem1[cmd_i.addr] <= (cmd_i.addr < AddrW'(GridSize)) ? OneQ16 : '0;
      mem2[cmd_i.addr] <= (cmd_i.addr < AddrW'(GridSize)) ? OneQ16 : '0;
    end else if (cmd_i.wr_res) begin
      mem1[cmd_i.addr] <= res1_q;
      mem2[cmd_i.addr] <= res2_q;
    end
    rd1_q <= mem1[cmd_i.addr];
    rd2_q <= mem2[cmd_i.addr];
  end

  // Count stores, cleared by a pass after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_counts || cmd_i.clr_counts) begin
      memc[cmd_i.addr] <= cmd_i.clr_counts ? 8'd0 : cancer_i;
      memn[cmd_i.addr] <= cmd_i.clr_counts ? 8'd0 : normal_i;
    end
    rdc_q <= memc[cmd_i.addr];
    rdn_q <= memn[cmd_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      tap_q <= TapC;
    end else begin
      rdv_q <= cmd_i.rd;
      tap_q <= cmd_i.rd_sel;
    end
  end

  // Capture taps as read data returns
  logic [ValW-1:0] c1_q, c2_q;
  logic [19:0]     s1_q, s2_q;
  logic [7:0]      cc_q, cn_q;
  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      if (tap_q == TapC) begin
        c1_q <= rd1_q; c2_q <= rd2_q; cc_q <= rdc_q; cn_q <= rdn_q;
        s1_q <= '0; s2_q <= '0;
      end else begin
        s1_q <= s1_q + 20'(rd1_q);
        s2_q <= s2_q + 20'(rd2_q);
      end
    end
  end
  assign rd_first_o  = rd1_q;
  assign rd_second_o = rd2_q;

  // Stage 1: laplacian, uptake sum, scaled value product
  logic signed [21:0] lap1_q, lap2_q;
  logic [24:0]        u1_q, u2_q;
  logic [32:0]        tv1_q, tv2_q;
  logic [3:0]         pv_q;
  always_ff @(posedge clk_i) begin
    lap1_q <= $signed({2'b0, s1_q}) - $signed({3'b0, c1_q, 2'b0});
    lap2_q <= $signed({2'b0, s2_q}) - $signed({3'b0, c2_q, 2'b0});
    u1_q   <= {9'd0, cn_q, 8'd0} + 25'(wc1_i) * 25'(cc_q);
    u2_q   <= {9'd0, cn_q, 8'd0} + 25'(wc2_i) * 25'(cc_q);
    tv1_q  <= step_i * c1_q;
    tv2_q  <= step_i * c2_q;
  end

  // Stage 2: diffusion term, uptake k, rounded sv
  logic signed [38:0] d1_q, d2_q;
  logic [40:0]        k1_q, k2_q;
  logic [16:0]        sv1_q, sv2_q;
  logic [ValW-1:0]    v1a_q, v2a_q, v1b_q, v2b_q;
  always_ff @(posedge clk_i) begin
    d1_q  <= $signed({1'b0, gain_i}) * lap1_q;
    d2_q  <= $signed({1'b0, gain_i}) * lap2_q;
    k1_q  <= alpha_i * u1_q;
    k2_q  <= alpha_i * u2_q;
    sv1_q <= 17'((tv1_q + 33'd32768) >> 16);
    sv2_q <= 17'((tv2_q + 33'd32768) >> 16);
    v1a_q <= c1_q; v2a_q <= c2_q;
    v1b_q <= v1a_q; v2b_q <= v2a_q;
  end

  // Stage 3: consumption product split on k into low 24 and high 17 bits
  logic [40:0] pl1_q, pl2_q;
  logic [33:0] ph1_q, ph2_q;
  logic signed [51:0] pd1_q, pd2_q;
  always_ff @(posedge clk_i) begin
    pl1_q <= sv1_q * k1_q[23:0];
    pl2_q <= sv2_q * k2_q[23:0];
    ph1_q <= sv1_q * k1_q[40:24];
    ph2_q <= sv2_q * k2_q[40:24];
    pd1_q <= $signed({1'b0, v1b_q, 16'd0}) + 52'(d1_q);
    pd2_q <= $signed({1'b0, v2b_q, 16'd0}) + 52'(d2_q);
  end

  // Stage 4: combine and saturate; a consumption of 2^40 or more always
  // exceeds the positive part, so it drives the result to zero
  logic [41:0] cons1, cons2;
  assign cons1 = {ph1_q[15:0], 24'd0} + 42'(pl1_q);
  assign cons2 = {ph2_q[15:0], 24'd0} + 42'(pl2_q);
  always_ff @(posedge clk_i) begin
    res1_q <= (|ph1_q[33:16]) ? '0 : sat_result(pd1_q - $signed({10'd0, cons1}));
    res2_q <= (|ph2_q[33:16]) ? '0 : sat_result(pd2_q - $signed({10'd0, cons2}));
  end

  // Track calc latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= '0;
    else         pv_q <= {pv_q[2:0], calc_i};
  end
  assign calc_done_o = pv_q[3];

endmodule

FILE: sv/nds_ctrl.sv
// ---------------------------------------------------------------------------
// nds_ctrl: sequencer for load, init, sweep and read operations
// Walks the grid for init and sweep and clears the count stores after reset.
// ---------------------------------------------------------------------------
module nds_ctrl
  import nds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nds_in_t    in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_done_o,
  output logic       out_rd_o,
  output nds_cmd_t   cmd_o,
  output logic       calc_o,
  input  logic       calc_done_i
);

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_TAP   = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [2:0]       tap_q, tap_d;
  logic             done_q, done_d, rdo_q, rdo_d;
  logic [AddrW-1:0] ra;
  logic [CoordW-1:0] ccol;
  logic             ins;

  assign ins = (32'(in_i.row) < GridSize) && (32'(in_i.col) < GridSize);
  assign ra  = AddrW'(32'(in_i.row) * GridSize + 32'(in_i.col));
  assign ccol = addr_q[CoordW-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_done_o  = done_q;
  assign out_rd_o    = rdo_q;

  // Next state and commands
  always_comb begin
    state_d = state_q; addr_d = addr_q; tap_d = tap_q;
    done_d = done_q; rdo_d = rdo_q;
    cmd_o = '0; cmd_o.addr = addr_q; calc_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_counts = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == AddrW'(Cells - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.addr = ra;
        if (in_valid_i) begin
          done_d = 1'b1; rdo_d = 1'b0;
          unique case (mode_e'(in_i.mode))
            MODE_LOAD: begin
              cmd_o.wr_counts = ins; done_d = ins; state_d = S_OUT;
            end
            MODE_INIT: begin addr_d = '0; state_d = S_INIT; end
            MODE_SWEEP: begin
              addr_d = AddrW'(GridSize + 1); tap_d = TapC; state_d = S_TAP;
            end
            MODE_READ: begin done_d = ins; rdo_d = ins; state_d = S_RD; end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.wr_init = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == AddrW'(Cells - 1)) state_d = S_OUT;
      end
      S_TAP: begin
        cmd_o.rd = 1'b1; cmd_o.rd_sel = tap_q;
        unique case (tap_q)
          TapN:    cmd_o.addr = addr_q - AddrW'(GridSize);
          TapS:    cmd_o.addr = addr_q + AddrW'(GridSize);
          TapW:    cmd_o.addr = addr_q - 1'b1;
          TapE:    cmd_o.addr = addr_q + 1'b1;
          default: cmd_o.addr = addr_q;
        endcase
        tap_d = tap_q + 1'b1;
        if (tap_q == TapE) state_d = S_WAIT;
      end
      S_WAIT: begin
        // last tap lands next cycle; then launch arithmetic
        if (tap_q == 3'd5) begin calc_o = 1'b1; tap_d = 3'd6; end
        else if (calc_done_i) state_d = S_WB;
        else if (tap_q != 3'd6) tap_d = tap_q + 1'b1;
      end
      S_WB: begin
        cmd_o.wr_res = 1'b1; tap_d = TapC; state_d = S_TAP;
        if (ccol == CoordW'(GridSize - 2)) begin
          addr_d = addr_q + 3'd3;
          if (addr_q == AddrW'(Cells - GridSize - 2)) state_d = S_OUT;
        end else addr_d = addr_q + 1'b1;
      end
      S_RD: state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; addr_q <= '0; tap_q <= TapC;
      done_q <= 1'b0; rdo_q <= 1'b0;
    end else begin
      state_q <= state_d; addr_q <= addr_d; tap_q <= tap_d;
      done_q <= done_d; rdo_q <= rdo_d;
    end
  end

endmodule

FILE: sv/nutrient_diffusion_sweep.sv
// ---------------------------------------------------------------------------
// nutrient_diffusion_sweep: two-field diffusion-reaction grid engine
// Top level: configuration registers, output register, controller, datapath.
// ---------------------------------------------------------------------------
// Init writes one cell per cycle, over all 4096 cells. A sweep visits each
// interior cell in turn: five stencil reads over the single field-memory
// port, a wait for the last read to land, four arithmetic stages and one
// write-back, for 62 * 62 interior cells. After reset a pass over all 4096
// cells clears the count stores, during which no item is accepted.
module nutrient_diffusion_sweep
  import nds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  nds_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output nds_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] gain_q, step_q, alpha_q, wc1_q, wc2_q;
  nds_cmd_t    cmd;
  logic        calc, calc_done, done, rdo;
  logic [16:0] rf, rs;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd6554; step_q <= 16'd655; alpha_q <= 16'd256;
      wc1_q <= 16'd256; wc2_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN:  gain_q  <= cfg_data_i;
        REG_STEP:  step_q  <= cfg_data_i;
        REG_ALPHA: alpha_q <= cfg_data_i;
        REG_WC1:   wc1_q   <= cfg_data_i;
        REG_WC2:   wc2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nds_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i(in_data_i),
    .out_valid_o, .out_ready_i, .out_done_o(done), .out_rd_o(rdo),
    .cmd_o(cmd), .calc_o(calc), .calc_done_i(calc_done)
  );

  nds_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .cancer_i(in_data_i.cancer_count), .normal_i(in_data_i.normal_count),
    .gain_i(gain_q), .step_i(step_q), .alpha_i(alpha_q),
    .wc1_i(wc1_q), .wc2_i(wc2_q),
    .calc_i(calc), .calc_done_o(calc_done),
    .rd_first_o(rf), .rd_second_o(rs)
  );

  // Hold read data once it lands
  logic [16:0] hf_q, hs_q;
  logic        lat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lat_q <= 1'b0;
    else         lat_q <= in_ready_o && in_valid_i && (in_data_i.mode == MODE_READ);
  end
  always_ff @(posedge clk_i) begin
    if (lat_q) begin hf_q <= rf; hs_q <= rs; end
  end

  assign out_data_o.nutrient_first  = rdo ? hf_q : '0;
  assign out_data_o.nutrient_second = rdo ? hs_q : '0;
  assign out_data_o.op_done         = done;

endmodule
